FILE: rtl/dts_pkg.sv
// Shared constants and types for the dependency topological sort block.
package dts_pkg;

  localparam int DTS_MAX_NODES = 64;
  localparam int HW_NODES      = 64;
  localparam int IDX_W         = 6;
  localparam int DEG_W         = 6;
  localparam int CNT_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 7;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ORDER = 1'd1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic inc;
    logic dec;
    logic clr;
  } dts_deg_ctl_t;

endpackage

FILE: rtl/dts_ram.sv
// Generic single write port RAM with a registered read port.
module dts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dts_degree.sv
// In-degree counters, one per node, with increment, row decrement and clear.
module dts_degree import dts_pkg::*; #(
  parameter int NODES = 64,
  parameter int NW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  dts_deg_ctl_t     ctl,
  input  logic [NW-1:0]    inc_idx,
  input  logic [NODES-1:0] dec_row,
  output logic [NODES-1:0] zero
);

  logic [DEG_W-1:0] deg [NODES];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NODES; i++) begin
      if (rst || ctl.clr) begin
        deg[i] <= '0;
      end else if (ctl.inc && (inc_idx == NW'(i))) begin
        deg[i] <= deg[i] + DEG_W'(1);
      end else if (ctl.dec && dec_row[i] && (deg[i] != '0)) begin
        deg[i] <= deg[i] - DEG_W'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      zero[i] = (deg[i] == '0);
    end
  end

endmodule

FILE: rtl/dts_pick.sv
// Selection unit: lowest ready node, or lowest open node when a cycle blocks.
module dts_pick #(
  parameter int NODES = 64,
  parameter int NW    = 6
) (
  input  logic [NODES-1:0] open_mask,
  input  logic [NODES-1:0] zero_mask,
  output logic [NW-1:0]    pick,
  output logic             broken
);

  logic [NODES-1:0] cand;
  logic [NODES-1:0] sel;

  assign cand   = open_mask & zero_mask;
  assign broken = (cand == '0);
  assign sel    = broken ? open_mask : cand;

  always_comb begin
    pick = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (sel[i]) begin
        pick = NW'(i);
      end
    end
  end

endmodule

FILE: rtl/dependency_topological_sort.sv
// Top level of the dependency topological sort block.
// Input beats on in_valid/in_ready carry kind, owner_index and dependent_index.
// A load beat (kind 0) adds the edge owner to dependent, or the reverse when
// reverse_order is set; self pairs, out-of-range indices and repeated edges
// are dropped. The adjacency row is read at the accepting edge and written
// back in the following cycle.
// A sort beat (kind 1) emits node_count result beats, at most NODES, on
// out_valid/out_ready in Kahn order, the final one with last set. Each result
// takes a priority pick, then an in-degree decrement from the adjacency row
// on the RAM read port.
// The block takes no input beat while a sort runs. When the receiver stalls,
// the result register holds and the sort waits for it to drain. After a sort
// the graph is cleared at once through row valid bits and counter clears.
// Reset clears the graph and sets node_count to 64 and reverse_order to 0.
// Configuration writes on cfg_wr_en take effect at the next edge in any state,
// so they must only be issued while the block is idle.
module dependency_topological_sort import dts_pkg::*; #(
  parameter int MAX_NODES = DTS_MAX_NODES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [IDX_W-1:0]      owner_index,
  input  logic [IDX_W-1:0]      dependent_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      node_index,
  output logic                  cycle_broken,
  output logic                  last
);

  localparam int NODES = (MAX_NODES < HW_NODES) ? MAX_NODES : HW_NODES;
  localparam int NW    = $clog2(NODES);
  localparam int CW    = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_LOAD_WR = 4'b0010,
    ST_PICK    = 4'b0100,
    ST_DEC     = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] node_count;
  logic             reverse_order;
  logic [CW-1:0]    n_eff;

  logic [NW-1:0]    from_reg;
  logic [NW-1:0]    to_reg;
  logic             edge_ok;
  logic [NW-1:0]    pick_reg;
  logic [NODES-1:0] placed;
  logic [NODES-1:0] row_valid;
  logic [CW-1:0]    placed_count;
  logic [CW-1:0]    count_inc;

  logic             in_fire;
  logic             own_ok;
  logic             dep_ok;
  logic [IDX_W-1:0] from_idx;
  logic [IDX_W-1:0] to_idx;

  logic [NODES-1:0] in_range;
  logic [NODES-1:0] open_mask;
  logic [NODES-1:0] zero_mask;
  logic [NW-1:0]    pick;
  logic             broken;

  logic             ram_we;
  logic [NW-1:0]    ram_raddr;
  logic [NODES-1:0] ram_wdata;
  logic [NODES-1:0] ram_rdata;
  logic [NODES-1:0] row;
  logic [NW-1:0]    row_addr;

  logic             sort_done;
  logic             slot_free;
  logic             do_pick;
  logic             new_edge;
  dts_deg_ctl_t     deg_ctl;

  assign n_eff = (node_count > CNT_W'(NODES)) ? CW'(NODES) : node_count[CW-1:0];

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign own_ok   = CNT_W'(owner_index) < CNT_W'(n_eff);
  assign dep_ok   = CNT_W'(dependent_index) < CNT_W'(n_eff);
  assign from_idx = reverse_order ? dependent_index : owner_index;
  assign to_idx   = reverse_order ? owner_index : dependent_index;

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      in_range[i] = (CW'(i) < n_eff);
    end
  end

  assign open_mask = in_range & ~placed;

  assign sort_done = (placed_count >= n_eff);
  assign slot_free = !out_valid || out_ready;
  assign do_pick   = (state == ST_PICK) && !sort_done && slot_free;
  assign count_inc = placed_count + CW'(1);

  assign ram_raddr = (state == ST_PICK) ? pick : from_idx[NW-1:0];
  assign row_addr  = (state == ST_DEC) ? pick_reg : from_reg;
  assign row       = row_valid[row_addr] ? ram_rdata : '0;
  assign new_edge  = (state == ST_LOAD_WR) && edge_ok && !row[to_reg];
  assign ram_we    = new_edge;
  assign ram_wdata = row | (NODES'(1) << to_reg);

  assign deg_ctl.inc = new_edge;
  assign deg_ctl.dec = (state == ST_DEC);
  assign deg_ctl.clr = (state == ST_PICK) && sort_done;

  dts_ram #(
    .WIDTH(NODES),
    .DEPTH(NODES)
  ) u_adj_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(from_reg),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dts_degree #(
    .NODES(NODES),
    .NW   (NW)
  ) u_degree (
    .clk    (clk),
    .rst    (rst),
    .ctl    (deg_ctl),
    .inc_idx(to_reg),
    .dec_row(row),
    .zero   (zero_mask)
  );

  dts_pick #(
    .NODES(NODES),
    .NW   (NW)
  ) u_pick (
    .open_mask(open_mask),
    .zero_mask(zero_mask),
    .pick     (pick),
    .broken   (broken)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (kind == KIND_SORT) ? ST_PICK : ST_LOAD_WR;
        end
      end
      ST_LOAD_WR: state_next = ST_IDLE;
      ST_PICK: begin
        if (sort_done) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          state_next = ST_DEC;
        end
      end
      ST_DEC:  state_next = ST_PICK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      node_count    <= NODE_COUNT_RESET;
      reverse_order <= 1'b0;
      placed        <= '0;
      row_valid     <= '0;
      placed_count  <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NODE_COUNT:    node_count <= cfg_data[CNT_W-1:0];
          REG_REVERSE_ORDER: reverse_order <= cfg_data[0];
          default: ;
        endcase
      end
      if (new_edge) begin
        row_valid[from_reg] <= 1'b1;
      end
      if (deg_ctl.clr) begin
        placed       <= '0;
        row_valid    <= '0;
        placed_count <= '0;
      end else if (do_pick) begin
        placed[pick] <= 1'b1;
        placed_count <= count_inc;
      end
      if (do_pick) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      from_reg <= from_idx[NW-1:0];
      to_reg   <= to_idx[NW-1:0];
      edge_ok  <= own_ok && dep_ok && (owner_index != dependent_index);
    end
    if (do_pick) begin
      pick_reg     <= pick;
      node_index   <= IDX_W'(pick);
      cycle_broken <= broken;
      last         <= (count_inc == n_eff);
    end
  end

endmodule
